// ===== rtl/core/tea_pkg.sv =====
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types and constants of the TEA block cipher pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tea_pkg;

	// round constant that the running sum advances by
	localparam logic [31:0] DELTA = 32'h9E3779B9;

	// shift amounts of the mix function
	localparam int SHIFT_LEFT  = 4;
	localparam int SHIFT_RIGHT = 5;

	// key register reset values
	localparam logic [31:0] KEY0_RESET = 32'h11111111;
	localparam logic [31:0] KEY1_RESET = 32'h22222222;
	localparam logic [31:0] KEY2_RESET = 32'h33333333;
	localparam logic [31:0] KEY3_RESET = 32'h44444444;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_KEY_WORD0 = 2'd0,
		REG_KEY_WORD1 = 2'd1,
		REG_KEY_WORD2 = 2'd2,
		REG_KEY_WORD3 = 2'd3
	} tea_reg_t;

	// operation codes
	localparam logic OP_ENCRYPT = 1'b0;
	localparam logic OP_DECRYPT = 1'b1;

	// block traveling down the pipeline
	typedef struct packed {
		logic        op;
		logic [31:0] left;
		logic [31:0] right;
	} tea_blk_t;

	// the full 128-bit key
	typedef struct packed {
		logic [31:0] k0;
		logic [31:0] k1;
		logic [31:0] k2;
		logic [31:0] k3;
	} tea_key_t;

	// per-stage control: advance enable, half-round phase, sum constants
	typedef struct packed {
		logic        en;
		logic        phase;
		logic [31:0] enc_sum;
		logic [31:0] dec_sum;
	} tea_stage_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/tea_in_if.sv =====
// ----------------------------------------------------------------------------
// tea_in_if
// Input channel: operation bit and the two halves of one 64-bit block.
// ----------------------------------------------------------------------------
`default_nettype none

interface tea_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [31:0] left_word;
	logic [31:0] right_word;

	modport source(output valid, output operation, output left_word, output right_word,
		input ready);
	modport sink(input valid, input operation, input left_word, input right_word,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tea_out_if.sv =====
// ----------------------------------------------------------------------------
// tea_out_if
// Output channel: the two halves of one transformed 64-bit block.
// ----------------------------------------------------------------------------
`default_nettype none

interface tea_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_left_word;
	logic [31:0] out_right_word;

	modport source(output valid, output out_left_word, output out_right_word, input ready);
	modport sink(input valid, input out_left_word, input out_right_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tea_half_round.sv =====
// ----------------------------------------------------------------------------
// tea_half_round
// One registered half round: updates one block half from the other half,
// adding the mix term for encryption or subtracting it for decryption.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_half_round (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire tea_pkg::tea_stage_ctl_t ctl,
	input  wire tea_pkg::tea_key_t      key,
	input  wire                         valid_in,
	input  wire tea_pkg::tea_blk_t      blk_in,
	output logic                        valid_out,
	output tea_pkg::tea_blk_t           blk_out
);

	logic              src_right;
	logic [31:0]       src;
	logic [31:0]       dst;
	logic [31:0]       kl;
	logic [31:0]       kr;
	logic [31:0]       sum;
	logic [31:0]       mix;
	logic [31:0]       dst_next;
	tea_pkg::tea_blk_t blk_next;
	logic              valid_s1;
	tea_pkg::tea_blk_t blk_s1;

	// encrypt even phase and decrypt odd phase read the right half
	assign src_right = (blk_in.op == ctl.phase);

	// operand and key selection
	always_comb begin
		if (src_right) begin
			src = blk_in.right;
			dst = blk_in.left;
			kl  = key.k0;
			kr  = key.k1;
		end else begin
			src = blk_in.left;
			dst = blk_in.right;
			kl  = key.k2;
			kr  = key.k3;
		end
		sum = (blk_in.op == tea_pkg::OP_DECRYPT) ? ctl.dec_sum : ctl.enc_sum;
	end

	// mix term and half update
	always_comb begin
		mix = ((src << tea_pkg::SHIFT_LEFT) + kl) ^ (src + sum)
			^ ((src >> tea_pkg::SHIFT_RIGHT) + kr);
		dst_next = (blk_in.op == tea_pkg::OP_DECRYPT) ? (dst - mix) : (dst + mix);
		blk_next = blk_in;
		if (src_right) begin
			blk_next.left = dst_next;
		end else begin
			blk_next.right = dst_next;
		end
	end

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ctl.en) begin
			valid_s1 <= valid_in;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			blk_s1 <= blk_next;
		end
	end

	assign valid_out = valid_s1;
	assign blk_out   = blk_s1;

endmodule

`default_nettype wire

// ===== rtl/core/tea_block_cipher.sv =====
// ----------------------------------------------------------------------------
// tea_block_cipher
// TEA encryption and decryption of 64-bit blocks under a 128-bit key,
// as a pipeline of registered half rounds.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  in_ch     sink       operation, left_word, right_word
//  out_ch    source     out_left_word, out_right_word
//  cfg_*     write      cfg_wr_en, cfg_index (key word 0..3), cfg_data
//
// one block enters per cycle while in_ch.ready is high; each transaction passes
// through one half round per pipeline stage (two 32-bit adds deep)
// reset clears the stage valid bits and loads the default key words
// a one-entry skid register after the last stage catches a result that is
// not taken; in_ch.ready drops only while that register is occupied
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher #(
	parameter int ROUND_COUNT = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	tea_in_if.sink      in_ch,
	tea_out_if.source   out_ch,
	input  wire         cfg_wr_en,
	input  wire  [1:0]  cfg_index,
	input  wire  [31:0] cfg_data
);

	localparam int STAGES = 2 * ROUND_COUNT;

	tea_pkg::tea_key_t key_q;
	logic              pipe_en;
	logic              stage_valid [STAGES+1];
	tea_pkg::tea_blk_t stage_blk   [STAGES+1];
	logic              skid_full_q;
	tea_pkg::tea_blk_t skid_blk_q;
	logic              last_valid;
	tea_pkg::tea_blk_t last_blk;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q.k0 <= tea_pkg::KEY0_RESET;
			key_q.k1 <= tea_pkg::KEY1_RESET;
			key_q.k2 <= tea_pkg::KEY2_RESET;
			key_q.k3 <= tea_pkg::KEY3_RESET;
		end else if (cfg_wr_en) begin
			unique case (tea_pkg::tea_reg_t'(cfg_index))
				tea_pkg::REG_KEY_WORD0: key_q.k0 <= cfg_data;
				tea_pkg::REG_KEY_WORD1: key_q.k1 <= cfg_data;
				tea_pkg::REG_KEY_WORD2: key_q.k2 <= cfg_data;
				tea_pkg::REG_KEY_WORD3: key_q.k3 <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline advances whenever the skid register is free
	assign pipe_en     = !skid_full_q;
	assign in_ch.ready = pipe_en;

	// pipeline entry
	assign stage_valid[0]     = in_ch.valid;
	assign stage_blk[0].op    = in_ch.operation;
	assign stage_blk[0].left  = in_ch.left_word;
	assign stage_blk[0].right = in_ch.right_word;

	// half-round stages
	for (genvar j = 0; j < STAGES; j++) begin : g_stage
		localparam int          ROUND    = j / 2;
		localparam logic [63:0] ENC_PROD = 64'(tea_pkg::DELTA) * 64'(ROUND + 1);
		localparam logic [63:0] DEC_PROD = 64'(tea_pkg::DELTA) * 64'(ROUND_COUNT - ROUND);

		tea_pkg::tea_stage_ctl_t ctl;

		assign ctl.en      = pipe_en;
		assign ctl.phase   = 1'(j % 2);
		assign ctl.enc_sum = ENC_PROD[31:0];
		assign ctl.dec_sum = DEC_PROD[31:0];

		tea_half_round u_half_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.key       (key_q),
			.valid_in  (stage_valid[j]),
			.blk_in    (stage_blk[j]),
			.valid_out (stage_valid[j+1]),
			.blk_out   (stage_blk[j+1])
		);
	end

	assign last_valid = stage_valid[STAGES];
	assign last_blk   = stage_blk[STAGES];

	// skid register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_ch.ready) begin
				skid_full_q <= 1'b0;
			end
		end else if (last_valid && !out_ch.ready) begin
			skid_full_q <= 1'b1;
		end
	end

	// skid register payload
	always_ff @(posedge clk) begin
		if (!skid_full_q) begin
			skid_blk_q <= last_blk;
		end
	end

	// output selection, skid entry is the older result
	assign out_ch.valid          = skid_full_q || last_valid;
	assign out_ch.out_left_word  = skid_full_q ? skid_blk_q.left  : last_blk.left;
	assign out_ch.out_right_word = skid_full_q ? skid_blk_q.right : last_blk.right;

	// skid only fills from a waiting result at the last stage
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(last_valid && !out_ch.ready))
		else $error("skid filled without a stalled result");

	// a held skid entry is never dropped before it is taken
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_full_q && !out_ch.ready) |=> (skid_full_q && $stable(skid_blk_q)))
		else $error("skid entry lost while stalled");

	// a stalled pipeline keeps its last stage unchanged
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> ($stable(last_valid) && (!last_valid || $stable(last_blk))))
		else $error("last stage moved during stall");

endmodule

`default_nettype wire

// ===== verif/tea_block_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// tea_block_cipher_tb
// Self-checking bench for the TEA block cipher pipeline. A short table of
// blocks under the default, all-zero and all-ones keys comes first. Random
// blocks under changing keys follow, with random idling on both channels and
// one long output hold that backs the pipeline up. Results are compared with a
// software model of the 32-round cipher kept inside the bench or with literal values.
// ----------------------------------------------------------------------------
`default_nettype none

module tea_block_cipher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROUND_COUNT  = 32;
	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 1250;
	localparam int LONG_HOLD    = 400;
	localparam int STUCK_LIMIT  = 2000;
	localparam int DRAIN_EXTRA  = 2 * ROUND_COUNT + 16;

	// key sets of the directed table
	localparam logic [1:0] KEYS_DEFAULT = 2'd0;
	localparam logic [1:0] KEYS_ZERO    = 2'd1;
	localparam logic [1:0] KEYS_ONES    = 2'd2;

	localparam tea_pkg::tea_key_t KEY_SETS [3] = '{
		{tea_pkg::KEY0_RESET, tea_pkg::KEY1_RESET, tea_pkg::KEY2_RESET, tea_pkg::KEY3_RESET},
		{4{32'h00000000}},
		{4{32'hFFFFFFFF}}
	};

	typedef struct packed {
		logic [31:0] left;
		logic [31:0] right;
	} block_pair_t;

	typedef struct packed {
		logic [1:0]  key_sel;
		logic        op;
		logic [31:0] left;
		logic [31:0] right;
		logic        lit;
		logic [31:0] exp_left;
		logic [31:0] exp_right;
	} block_row_t;

	// directed table; two rows give the known answer for the all-zero key and block
	localparam int DIRECTED_ROWS = 21;
	localparam block_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{KEYS_DEFAULT, tea_pkg::OP_ENCRYPT, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
		'{KEYS_DEFAULT, tea_pkg::OP_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0},
		'{KEYS_DEFAULT, tea_pkg::OP_ENCRYPT, 32'h00000000, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0},
		'{KEYS_DEFAULT, tea_pkg::OP_ENCRYPT, 32'hFFFFFFFF, 32'h00000000, 1'b0, 32'h0, 32'h0},
		'{KEYS_DEFAULT, tea_pkg::OP_ENCRYPT, 32'hAAAAAAAA, 32'h55555555, 1'b0, 32'h0, 32'h0},
		'{KEYS_DEFAULT, tea_pkg::OP_ENCRYPT, 32'h80000000, 32'h00000001, 1'b0, 32'h0, 32'h0},
		'{KEYS_DEFAULT, tea_pkg::OP_DECRYPT, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
		'{KEYS_DEFAULT, tea_pkg::OP_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0},
		'{KEYS_DEFAULT, tea_pkg::OP_DECRYPT, 32'h00000000, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0},
		'{KEYS_DEFAULT, tea_pkg::OP_DECRYPT, 32'hFFFFFFFF, 32'h00000000, 1'b0, 32'h0, 32'h0},
		'{KEYS_DEFAULT, tea_pkg::OP_DECRYPT, 32'h55555555, 32'hAAAAAAAA, 1'b0, 32'h0, 32'h0},
		'{KEYS_ZERO, tea_pkg::OP_ENCRYPT, 32'h00000000, 32'h00000000, 1'b1,
			32'h41EA3A0A, 32'h94BAA940},
		'{KEYS_ZERO, tea_pkg::OP_DECRYPT, 32'h41EA3A0A, 32'h94BAA940, 1'b1,
			32'h00000000, 32'h00000000},
		'{KEYS_ZERO, tea_pkg::OP_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0},
		'{KEYS_ZERO, tea_pkg::OP_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0},
		'{KEYS_ONES, tea_pkg::OP_ENCRYPT, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
		'{KEYS_ONES, tea_pkg::OP_ENCRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0},
		'{KEYS_ONES, tea_pkg::OP_DECRYPT, 32'h00000000, 32'h00000000, 1'b0, 32'h0, 32'h0},
		'{KEYS_ONES, tea_pkg::OP_DECRYPT, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 32'h0},
		'{KEYS_ONES, tea_pkg::OP_ENCRYPT, 32'h12345678, 32'h9ABCDEF0, 1'b0, 32'h0, 32'h0},
		'{KEYS_ONES, tea_pkg::OP_DECRYPT, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b0, 32'h0, 32'h0}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	tea_pkg::tea_reg_t cfg_index;
	logic [31:0]       cfg_data;

	tea_in_if  in_ch ();
	tea_out_if out_ch ();

	tea_block_cipher #(
		.ROUND_COUNT(ROUND_COUNT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// bench copy of the key registers and the blocks still in flight
	tea_pkg::tea_key_t key_model;
	block_pair_t       transformed_q [$];

	bit src_idle_on;
	bit sink_idle_on;
	bit hold_req;

	int error_count;
	int results_checked;
	int blocks_sent;
	int decrypts_sent;
	int key_settings;
	int holds_done;
	int stuck_cycles;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// one TEA half-round mix term
	function automatic logic [31:0] tea_mix(logic [31:0] v, logic [31:0] sum,
		logic [31:0] kl, logic [31:0] kr);
		return ((v << tea_pkg::SHIFT_LEFT) + kl) ^ (v + sum)
			^ ((v >> tea_pkg::SHIFT_RIGHT) + kr);
	endfunction

	// full encrypt or decrypt of one block under a key
	function automatic block_pair_t tea_transform(logic op, logic [31:0] l,
		logic [31:0] r, tea_pkg::tea_key_t k);
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] sum;
		x = l;
		y = r;
		if (op == tea_pkg::OP_ENCRYPT) begin
			sum = 32'h0;
			for (int i = 0; i < ROUND_COUNT; i++) begin
				sum = sum + tea_pkg::DELTA;
				x = x + tea_mix(y, sum, k.k0, k.k1);
				y = y + tea_mix(x, sum, k.k2, k.k3);
			end
		end else begin
			sum = tea_pkg::DELTA * ROUND_COUNT;
			for (int i = 0; i < ROUND_COUNT; i++) begin
				y = y - tea_mix(x, sum, k.k2, k.k3);
				x = x - tea_mix(y, sum, k.k0, k.k1);
				sum = sum - tea_pkg::DELTA;
			end
		end
		return {x, y};
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// random word leaning toward edge patterns
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h00000000;
			1: return 32'hFFFFFFFF;
			2: return 32'h1 << $urandom_range(0, 31);
			3: return ~(32'h1 << $urandom_range(0, 31));
			default: return $urandom();
		endcase
	endfunction

	// offer one block and wait for its transaction
	task automatic send_block(input logic op, input logic [31:0] l, input logic [31:0] r,
		input block_pair_t want);
		int gap;
		gap = src_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.operation  <= op;
		in_ch.left_word  <= l;
		in_ch.right_word <= r;
		do @(posedge clk); while (!in_ch.ready);
		transformed_q = {transformed_q, want};
		blocks_sent++;
		if (op == tea_pkg::OP_DECRYPT)
			decrypts_sent++;
	endtask

	// stop offering and wait until every block has come back
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (transformed_q.size() != 0) @(posedge clk);
	endtask

	// write the key words selected by mask, back to back
	task automatic write_keys(input tea_pkg::tea_key_t k, input logic [3:0] mask);
		logic [31:0] word;
		for (int i = 0; i < 4; i++) begin
			if (mask[i]) begin
				case (tea_pkg::tea_reg_t'(i))
					tea_pkg::REG_KEY_WORD0: begin
						word = k.k0;
						key_model.k0 = word;
					end
					tea_pkg::REG_KEY_WORD1: begin
						word = k.k1;
						key_model.k1 = word;
					end
					tea_pkg::REG_KEY_WORD2: begin
						word = k.k2;
						key_model.k2 = word;
					end
					default: begin
						word = k.k3;
						key_model.k3 = word;
					end
				endcase
				cfg_wr_en <= 1'b1;
				cfg_index <= tea_pkg::tea_reg_t'(i);
				cfg_data  <= word;
				@(posedge clk);
			end
		end
		cfg_wr_en <= 1'b0;
		key_settings++;
	endtask

	// result checker against the oldest block in flight
	always @(posedge clk) begin : result_check
		block_pair_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (transformed_q.size() == 0) begin
				$error("result %h %h with no block in flight",
					out_ch.out_left_word, out_ch.out_right_word);
				error_count++;
			end else begin
				want = transformed_q.pop_front();
				results_checked++;
				if (out_ch.out_left_word !== want.left) begin
					$error("out_left_word: expected %h, actual %h",
						want.left, out_ch.out_left_word);
					error_count++;
				end
				if (out_ch.out_right_word !== want.right) begin
					$error("out_right_word: expected %h, actual %h",
						want.right, out_ch.out_right_word);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout with %0d blocks in flight", transformed_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	// output side: random stalls plus the long hold on request
	initial begin : sink_side
		int gap;
		out_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
				gap = pick_gap();
				if (gap > 0) begin
					out_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// reset, directed table, then random phases
	initial begin : source_side
		logic [1:0]        cur_sel;
		block_row_t        row;
		block_pair_t       want;
		logic              op;
		logic [31:0]       l;
		logic [31:0]       r;
		tea_pkg::tea_key_t next_key;
		logic [3:0]        mask;
		int                phase_len;
		int                phase_no;
		int                random_sent;

		arst_n           <= 1'b0;
		cfg_wr_en        <= 1'b0;
		cfg_index        <= tea_pkg::REG_KEY_WORD0;
		cfg_data         <= 32'h0;
		in_ch.valid      <= 1'b0;
		in_ch.operation  <= tea_pkg::OP_ENCRYPT;
		in_ch.left_word  <= 32'h0;
		in_ch.right_word <= 32'h0;
		key_model    = KEY_SETS[KEYS_DEFAULT];
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		hold_req     = 1'b0;
		cur_sel      = KEYS_DEFAULT;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, default key straight out of reset
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.key_sel != cur_sel) begin
				drain_results();
				write_keys(KEY_SETS[row.key_sel], 4'hF);
				cur_sel = row.key_sel;
			end
			if (row.lit)
				want = {row.exp_left, row.exp_right};
			else
				want = tea_transform(row.op, row.left, row.right, key_model);
			send_block(row.op, row.left, row.right, want);
		end

		// random phases, each under a fresh key setting
		phase_no    = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			drain_results();
			case ($urandom_range(0, 5))
				0: begin
					next_key = KEY_SETS[KEYS_ZERO];
					mask = 4'hF;
				end
				1: begin
					next_key = KEY_SETS[KEYS_ONES];
					mask = 4'hF;
				end
				default: begin
					next_key = {pick_word(), pick_word(), pick_word(), pick_word()};
					mask = (phase_no == 0) ? 4'hF : 4'($urandom_range(1, 15));
				end
			endcase
			write_keys(next_key, mask);
			src_idle_on  = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			phase_len    = $urandom_range(30, 120);
			// back the pipeline up once while the input keeps offering
			if (phase_no == 2) begin
				src_idle_on = 1'b0;
				hold_req    = 1'b1;
				phase_len   = 200;
			end
			// last phase stops at the item budget
			if (phase_len > RANDOM_ITEMS - random_sent)
				phase_len = RANDOM_ITEMS - random_sent;
			for (int n = 0; n < phase_len; n++) begin
				op = 1'($urandom_range(0, 1));
				l  = pick_word();
				r  = pick_word();
				send_block(op, l, r, tea_transform(op, l, r, key_model));
				random_sent++;
			end
			phase_no++;
		end

		drain_results();
		repeat (DRAIN_EXTRA) @(posedge clk);

		$display("covered %0d blocks (%0d decrypt) under %0d key settings",
			blocks_sent, decrypts_sent, key_settings);
		$display("checked %0d results, %0d long output hold(s), %0d mismatch(es)",
			results_checked, holds_done, error_count);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/tea_pkg.sv
rtl/core/tea_in_if.sv
rtl/core/tea_out_if.sv
rtl/core/tea_half_round.sv
rtl/core/tea_block_cipher.sv
verif/tea_block_cipher_tb.sv
